@@ hw/rtl/rde_pkg.sv @@
package rde_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int MAX_BASE    = 16;
  // one cell per possible digit, radix two gives the longest string
  localparam int DIGIT_CELLS = VALUE_BITS;

  localparam int DIG_W    = (MAX_BASE > 2) ? $clog2(MAX_BASE) : 1;
  localparam int RAD_W    = DIG_W + 1;
  localparam int CIDX_W   = $clog2(DIGIT_CELLS);
  localparam int CNT_W    = $clog2(DIGIT_CELLS + 1);
  localparam int CYC_W    = $clog2(VALUE_BITS + DIGIT_CELLS);
  localparam int BLEN_W   = 5;
  localparam int SYM_BITS = 128;
  localparam int KCNT_W   = 6;

  localparam logic [1:0] CFG_BASE_LENGTH  = 2'd0;
  localparam logic [1:0] CFG_SYMBOLS_LOW  = 2'd1;
  localparam logic [1:0] CFG_SYMBOLS_HIGH = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] n_digits;
  } conv_stat_t;

endpackage

@@ hw/rtl/rde_base_check.sv @@
module rde_base_check (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [rde_pkg::BLEN_W-1:0]   base_length,
  input  logic [rde_pkg::SYM_BITS-1:0] symbols,
  output logic                         base_ok
);
  import rde_pkg::*;

  logic bad;
  logic base_ok_r;

  // symbols past the table length are don't-care
  always_comb begin
    logic [7:0] s;
    bad = (base_length < BLEN_W'(2)) || (base_length > BLEN_W'(MAX_BASE));
    for (int i = 0; i < MAX_BASE; i++) begin
      s = symbols[i*8 +: 8];
      if (base_length > BLEN_W'(i)) begin
        if (s == CH_NUL || s == CH_SPACE || (s >= CH_TAB && s <= CH_CR) ||
            s == CH_PLUS || s == CH_MINUS) begin
          bad = 1'b1;
        end
        for (int j = 0; j < i; j++) begin
          if (symbols[j*8 +: 8] == s) bad = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_ok_r <= 1'b0;
    end else begin
      base_ok_r <= !bad;
    end
  end

  assign base_ok = base_ok_r;

endmodule

@@ hw/rtl/rde_digit_array.sv @@
module rde_digit_array (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [rde_pkg::VALUE_BITS-1:0] value,
  input  logic [rde_pkg::RAD_W-1:0]      radix,
  input  logic [rde_pkg::CIDX_W-1:0]     rd_idx,
  output logic [rde_pkg::DIG_W-1:0]      rd_digit,
  output rde_pkg::conv_stat_t            stat
);
  import rde_pkg::*;

  localparam logic [CYC_W-1:0] CYC_LAST = CYC_W'(VALUE_BITS + DIGIT_CELLS - 1);

  logic [VALUE_BITS-1:0]  val_r;
  logic [DIG_W-1:0]       cell_r   [DIGIT_CELLS];
  logic [DIG_W-1:0]       cell_nxt [DIGIT_CELLS];
  logic [DIG_W:0]         sum      [DIGIT_CELLS];
  logic [DIG_W:0]         diff     [DIGIT_CELLS];
  logic [DIGIT_CELLS-1:0] tok_r, cy_r, seen_r;
  logic [DIGIT_CELLS-1:0] tok_in, cin, cy_nxt, nz;
  logic [CYC_W-1:0]       cyc_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   running_r;
  logic                   feed_vld;
  logic                   adv;

  // value bits enter msb first; each cell doubles its digit and adds the
  // carry from below in the cycle after its lower neighbor did the same step
  assign feed_vld = running_r && (cyc_r < CYC_W'(VALUE_BITS));
  assign tok_in   = {tok_r[DIGIT_CELLS-2:0], feed_vld};
  assign cin      = {cy_r[DIGIT_CELLS-2:0], val_r[VALUE_BITS-1]};

  always_comb begin
    for (int i = 0; i < DIGIT_CELLS; i++) begin
      sum[i]  = {cell_r[i], cin[i]};
      diff[i] = sum[i] - radix;
      cy_nxt[i] = tok_in[i] && (sum[i] >= radix);
      if (!tok_in[i]) begin
        cell_nxt[i] = cell_r[i];
      end else if (cy_nxt[i]) begin
        cell_nxt[i] = diff[i][DIG_W-1:0];
      end else begin
        cell_nxt[i] = sum[i][DIG_W-1:0];
      end
      nz[i] = (cell_nxt[i] != '0);
    end
  end

  // cells that ever held a nonzero digit form a run from cell 0 upward,
  // so the digit count walks up that run one cell a cycle
  assign adv = (cnt_r < CNT_W'(DIGIT_CELLS)) && seen_r[cnt_r[CIDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      cyc_r     <= '0;
      cnt_r     <= '0;
      tok_r     <= '0;
      cy_r      <= '0;
      seen_r    <= '0;
    end else if (start) begin
      running_r <= 1'b1;
      cyc_r     <= '0;
      cnt_r     <= '0;
      tok_r     <= '0;
      cy_r      <= '0;
      seen_r    <= '0;
    end else begin
      if (running_r) begin
        cyc_r <= cyc_r + CYC_W'(1);
        if (cyc_r == CYC_LAST) running_r <= 1'b0;
      end
      tok_r  <= tok_in;
      cy_r   <= cy_nxt;
      seen_r <= seen_r | nz;
      if (adv) cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r <= value;
    end else if (feed_vld) begin
      val_r <= {val_r[VALUE_BITS-2:0], 1'b0};
    end
    for (int i = 0; i < DIGIT_CELLS; i++) begin
      cell_r[i] <= (!rst_n || start) ? '0 : cell_nxt[i];
    end
  end

  assign rd_digit      = cell_r[rd_idx];
  assign stat.done     = !running_r && !adv;
  assign stat.n_digits = cnt_r;

endmodule

@@ hw/rtl/radix_digit_emitter.sv @@
// first character: with a prefix or a zero value it is loaded from the prefix
// or zero state without waiting for a conversion, otherwise only once the skewed
// doubling array in rde_digit_array has finished the conversion
// throughput: one item at a time; a new value is taken only in the idle state,
// input held off during a register write and the cycle after it
// reset: synchronous active-low rst_n clears control, table and digit state
module radix_digit_emitter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[31:0]
  input  logic [0:0]  in_tuser,   // with_prefix
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // char_code[7:0], chars_so_far[13:8], zero fill
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  import rde_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PFX0 = 3'd1;
  localparam logic [2:0] ST_PFX1 = 3'd2;
  localparam logic [2:0] ST_ZERO = 3'd3;
  localparam logic [2:0] ST_CONV = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [BLEN_W-1:0]  base_len_r;
  logic [63:0]        sym_lo_r, sym_hi_r;
  logic [SYM_BITS-1:0] sym_tab;
  logic               base_ok;
  logic               cfg_recent_r;

  logic [2:0]         state_r, state_nxt;
  logic               zero_r;
  logic [CIDX_W-1:0]  ptr_r;
  logic [KCNT_W-1:0]  k_r;
  logic               out_valid_r, out_last_r;
  logic [7:0]         out_char_r;
  logic [KCNT_W-1:0]  out_cnt_r;

  logic               accept, in_zero, conv_start, load;
  logic               emit_act, emit_last;
  logic [7:0]         emit_char, sym_char;
  logic [DIG_W-1:0]   dig;
  conv_stat_t         cstat;

  assign sym_tab = {sym_hi_r, sym_lo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_len_r <= '0;
      sym_lo_r   <= '0;
      sym_hi_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_LENGTH:  base_len_r <= cfg_wdata[BLEN_W-1:0];
        CFG_SYMBOLS_LOW:  sym_lo_r   <= cfg_wdata;
        CFG_SYMBOLS_HIGH: sym_hi_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // the table check is registered, so it lags the table registers; input is held off in the cycle after a write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_recent_r <= 1'b0;
    end else begin
      cfg_recent_r <= cfg_we;
    end
  end

  rde_base_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .base_length (base_len_r),
    .symbols     (sym_tab),
    .base_ok     (base_ok)
  );

  assign in_tready  = (state_r == ST_IDLE) && !cfg_we && !cfg_recent_r;
  assign accept     = in_tvalid && in_tready;
  assign in_zero    = (in_tdata[VALUE_BITS-1:0] == '0);
  assign conv_start = accept && !in_zero && base_ok;

  rde_digit_array u_digits (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (conv_start),
    .value    (in_tdata[VALUE_BITS-1:0]),
    .radix    (base_len_r[RAD_W-1:0]),
    .rd_idx   (ptr_r),
    .rd_digit (dig),
    .stat     (cstat)
  );

  assign sym_char = sym_tab[{dig, 3'b000} +: 8];
  // output register frees up when empty or when its beat is taken
  assign load     = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    emit_act  = 1'b0;
    emit_last = 1'b0;
    emit_char = CH_ZERO;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser[0]) state_nxt = ST_PFX0;
          else if (in_zero) state_nxt = ST_ZERO;
          else if (base_ok) state_nxt = ST_CONV;
        end
      end
      ST_PFX0: begin
        emit_act = load;
        if (load) state_nxt = ST_PFX1;
      end
      ST_PFX1: begin
        emit_act  = load;
        emit_char = CH_X;
        emit_last = !zero_r && !base_ok;
        if (load) begin
          if (zero_r) state_nxt = ST_ZERO;
          else if (base_ok) state_nxt = ST_CONV;
          else state_nxt = ST_IDLE;
        end
      end
      ST_ZERO: begin
        emit_act  = load;
        emit_last = 1'b1;
        if (load) state_nxt = ST_IDLE;
      end
      ST_CONV: begin
        if (cstat.done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        emit_act  = load;
        emit_char = sym_char;
        emit_last = (ptr_r == '0);
        if (load && ptr_r == '0) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) k_r <= '0;
      else if (emit_act) k_r <= k_r + KCNT_W'(1);
      if (emit_act) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) zero_r <= in_zero;
    if (state_r == ST_CONV && cstat.done) begin
      ptr_r <= CIDX_W'(cstat.n_digits - CNT_W'(1));
    end else if (state_r == ST_EMIT && emit_act) begin
      ptr_r <= ptr_r - CIDX_W'(1);
    end
    if (emit_act) begin
      out_char_r <= emit_char;
      out_last_r <= emit_last;
      out_cnt_r  <= k_r + KCNT_W'(1);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_cnt_r, out_char_r};
  assign out_tlast  = out_last_r;

endmodule
